FILE: rtl/core/tskf_pkg.sv
package tskf_pkg;

    // Sequencer states of the fusion core.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DIV,
        S_MULX,
        S_MULY,
        S_MULV,
        S_FIN
    } t_state;

    // Sensor status codes reported with each estimate.
    typedef logic [1:0] t_status;
    localparam t_status ST_BOTH   = 2'd0;
    localparam t_status ST_FORCE  = 2'd1;
    localparam t_status ST_CAMERA = 2'd2;
    localparam t_status ST_NONE   = 2'd3;

    // Configuration register indexes (word address).
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_PROCESS_VAR = 2'd0;
    localparam t_reg_idx REG_MEAS_VAR    = 2'd1;
    localparam t_reg_idx REG_INIT_VAR    = 2'd2;

    // Reset value of every variance register and of the running variance.
    localparam logic [31:0] VAR_RESET = 32'h0001_0000;

endpackage

FILE: rtl/core/two_sensor_kalman_fusion_core.sv
// Two-sensor position fuser built as a Kalman filter with identity models, so the
// covariance is a single variance value. Each request carries a force-sensor pose and a
// camera pose with their valid flags; the prior is the force pose (or the last estimate),
// the measurement is the mean of the valid poses, and the gain p/(p+r) is produced by a
// restoring divider that retires one quotient bit per cycle. A request passes through a
// divider setup state, FRAC_BITS+1 divider steps, a single shared multiplier used in turn
// for the two axes and the variance, and then a finish state. The input is ready only
// while the core is idle, which begins as the result is loaded, so the core takes no new
// request until it is through with the last one. A finished result sits in an output
// register, so the next request may enter while it waits; the finish state holds until
// that register is free. The initial variance register is readable and writable but the
// running variance always restarts from its reset value.
module two_sensor_kalman_fusion_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Input request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_force_x,
    input  logic signed [31:0]   i_force_y,
    input  logic                 i_force_ok,
    input  logic signed [31:0]   i_camera_x,
    input  logic signed [31:0]   i_camera_y,
    input  logic                 i_camera_ok,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_estimate_x,
    output logic signed [31:0]   o_estimate_y,
    output tskf_pkg::t_status    o_sensor_status
);
    import tskf_pkg::*;

    // Gain width, counter width, product width and shifted product width.
    localparam int KW = FRAC_BITS + 1;
    localparam int CW = $clog2(KW);
    localparam int PW = 34 + KW + 1;
    localparam int SW = PW - FRAC_BITS;
    localparam logic [KW-1:0] K_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SW-1:0] EST_MAX = {{(SW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] EST_MIN = {{(SW-31){1'b1}}, {31{1'b0}}};

    // Configuration registers.
    logic [31:0] r_pv;
    logic [31:0] r_mv;
    logic [31:0] r_iv;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= VAR_RESET;
            r_mv <= VAR_RESET;
            r_iv <= VAR_RESET;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_PROCESS_VAR: r_pv <= pwdata;
                REG_MEAS_VAR:    r_mv <= pwdata;
                REG_INIT_VAR:    r_iv <= pwdata;
                default:         ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_PROCESS_VAR: prdata = r_pv;
            REG_MEAS_VAR:    prdata = r_mv;
            REG_INIT_VAR:    prdata = r_iv;
            default:         prdata = 32'd0;
        endcase
    end

    // Filter state and per-request working registers.
    t_state             r_state;
    t_state             n_state;
    logic [31:0]        r_var;
    logic signed [31:0] r_last_x;
    logic signed [31:0] r_last_y;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_zx;
    logic signed [31:0] r_zy;
    t_status            r_status;
    logic [31:0]        r_p;
    logic [32:0]        r_den;
    logic [32:0]        r_rem;
    logic [KW-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic signed [PW-1:0] r_prod;
    logic signed [31:0] r_ex;
    logic signed [31:0] r_ey;
    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    t_status            r_out_status;

    logic               accept;
    logic               out_free;
    logic [32:0]        p_sum;
    logic [31:0]        p_sat;
    logic signed [32:0] sum_x;
    logic signed [32:0] sum_y;
    t_status            in_status;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Variance growth with saturation, and the mean of both poses.
    assign p_sum = {1'b0, r_var} + {1'b0, r_pv};
    assign p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    assign sum_x = 33'(i_force_x) + 33'(i_camera_x);
    assign sum_y = 33'(i_force_y) + 33'(i_camera_y);

    always_comb begin
        if (i_force_ok && i_camera_ok) begin
            in_status = ST_BOTH;
        end else if (i_force_ok) begin
            in_status = ST_FORCE;
        end else if (i_camera_ok) begin
            in_status = ST_CAMERA;
        end else begin
            in_status = ST_NONE;
        end
    end

    // Divider step: shift in the next dividend bit and subtract when it fits.
    logic [33:0]   rem_sh;
    logic          rem_ge;
    logic [KW-1:0] q_next;
    logic          div_last;
    logic          k_kill;

    assign rem_sh   = {r_rem, (r_cnt == '0) ? r_p[0] : 1'b0};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});
    assign q_next   = {r_q[KW-2:0], rem_ge};
    assign div_last = (r_cnt == CW'(KW - 1));
    assign k_kill   = (r_status == ST_NONE) || (r_den == '0);

    // Shared multiplier: x difference, y difference, then the variance update.
    logic signed [33:0]   mul_a;
    logic [KW-1:0]        mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_MULX: begin
                mul_a = 34'(r_zx) - 34'(r_px);
                mul_b = r_q;
            end
            S_MULY: begin
                mul_a = 34'(r_zy) - 34'(r_py);
                mul_b = r_q;
            end
            S_MULV: begin
                mul_a = signed'({2'b00, r_p});
                mul_b = K_ONE - r_q;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(signed'({1'b0, mul_b}));

    // Estimate = prior + floor(k * diff / one), clamped to 32 bits.
    logic signed [31:0]   est_prior;
    logic signed [SW-1:0] est_wide;
    logic signed [31:0]   est_sat;

    assign est_prior = (r_state == S_MULY) ? r_px : r_py;
    assign est_wide  = SW'(est_prior) + r_prod[PW-1:FRAC_BITS];

    always_comb begin
        if (est_wide > EST_MAX) begin
            est_sat = 32'sh7FFF_FFFF;
        end else if (est_wide < EST_MIN) begin
            est_sat = 32'sh8000_0000;
        end else begin
            est_sat = est_wide[31:0];
        end
    end

    logic [31:0] var_next;
    assign var_next = r_prod[FRAC_BITS +: 32];

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_INIT;
            S_INIT: n_state = S_DIV;
            S_DIV:  if (div_last) n_state = S_MULX;
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_MULV;
            S_MULV: n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px     <= i_force_ok ? i_force_x : r_last_x;
                r_py     <= i_force_ok ? i_force_y : r_last_y;
                r_status <= in_status;
                r_p      <= p_sat;
                case (in_status)
                    ST_BOTH: begin
                        r_zx <= sum_x[32:1];
                        r_zy <= sum_y[32:1];
                    end
                    ST_FORCE: begin
                        r_zx <= i_force_x;
                        r_zy <= i_force_y;
                    end
                    default: begin
                        r_zx <= i_camera_x;
                        r_zy <= i_camera_y;
                    end
                endcase
            end
            S_INIT: begin
                r_den <= {1'b0, r_p} + {1'b0, r_mv};
                r_rem <= {2'b00, r_p[31:1]};
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= rem_ge ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
                r_q   <= (div_last && k_kill) ? '0 : q_next;
                r_cnt <= r_cnt + 1'b1;
            end
            S_MULX: begin
                r_prod <= mul_p;
            end
            S_MULY: begin
                r_prod <= mul_p;
                r_ex   <= est_sat;
            end
            S_MULV: begin
                r_prod <= mul_p;
                r_ey   <= est_sat;
            end
            default: ;
        endcase
    end

    // Filter state and result register, updated when the result is handed off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var       <= VAR_RESET;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_var        <= var_next;
            r_last_x     <= r_ex;
            r_last_y     <= r_ey;
            r_out_valid  <= 1'b1;
            r_out_x      <= r_ex;
            r_out_y      <= r_ey;
            r_out_status <= r_status;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_estimate_x    = r_out_x;
    assign o_estimate_y    = r_out_y;
    assign o_sensor_status = r_out_status;

    // An accepted request always starts the divider setup.
    a_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_INIT))
        else $error("accepted request did not start divider setup");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    // The gain never exceeds one, and is zero when no sensor is valid.
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULX) |-> (r_q <= K_ONE && (r_status != ST_NONE || r_q == '0)))
        else $error("gain out of range");

    // The updated variance never exceeds the grown variance.
    a_var_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (var_next <= r_p))
        else $error("variance grew in the update");

endmodule
